[design/tlptw_pkg.sv]
// Package for the two-level page table walk: constants, step codes and the control store.
package tlptw_pkg;

  localparam int unsigned MemBytes  = 4096;
  localparam int unsigned AddrW     = 12;
  localparam int unsigned Banks     = 4;
  localparam int unsigned BankSelW  = 2;
  localparam int unsigned RowW      = AddrW - BankSelW;
  localparam int unsigned BankDepth = MemBytes / Banks;
  localparam int unsigned VaW       = 14;
  localparam int unsigned OffW      = 6;
  localparam int unsigned FrameW    = 6;
  localparam int unsigned WordW     = 32;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  // step codes of the microprogram
  localparam int unsigned StepW = 3;
  localparam logic [StepW-1:0] S_IDLE  = 3'd0;
  localparam logic [StepW-1:0] S_OUTER = 3'd1;
  localparam logic [StepW-1:0] S_INNER = 3'd2;
  localparam logic [StepW-1:0] S_DATA  = 3'd3;
  localparam logic [StepW-1:0] S_EMIT  = 3'd4;

  typedef enum logic [1:0] {
    AS_NONE,
    AS_OUTER,
    AS_INNER,
    AS_PA
  } addr_sel_e;

  typedef struct packed {
    logic             wait_in;    // step waits for an input beat
    logic             test_ok;    // read word bit 0 must be set, else miss
    addr_sel_e        sel;        // address of the read issued by this step
    logic             chk_range;  // table address must stay below MemBytes
    logic             set_outer;
    logic             set_inner;
    logic             emit;       // step writes the result register
    logic             emit_word;  // result carries the read word
    logic [StepW-1:0] next;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t cw;
    cw = '{wait_in: 1'b0, test_ok: 1'b0, sel: AS_NONE, chk_range: 1'b0,
           set_outer: 1'b0, set_inner: 1'b0, emit: 1'b0, emit_word: 1'b0,
           next: S_IDLE};
    case (step)
      S_IDLE: begin
        cw.wait_in   = 1'b1;
        cw.sel       = AS_OUTER;
        cw.chk_range = 1'b1;
        cw.next      = S_OUTER;
      end
      S_OUTER: begin
        cw.test_ok   = 1'b1;
        cw.sel       = AS_INNER;
        cw.chk_range = 1'b1;
        cw.set_outer = 1'b1;
        cw.next      = S_INNER;
      end
      S_INNER: begin
        cw.test_ok   = 1'b1;
        cw.sel       = AS_PA;
        cw.set_inner = 1'b1;
        cw.next      = S_DATA;
      end
      S_DATA: begin
        cw.emit      = 1'b1;
        cw.emit_word = 1'b1;
        cw.next      = S_IDLE;
      end
      S_EMIT: begin
        cw.emit = 1'b1;
        cw.next = S_IDLE;
      end
      default: begin
        cw.next = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

[design/tlptw_if.sv]
// Channel interfaces of the page table walk: request, response and configuration.
interface tlptw_req_if;
  import tlptw_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [AddrW-1:0] load_address;
  logic [7:0]       load_byte;
  logic [VaW-1:0]   virtual_address;

  modport source (output valid, mode, load_address, load_byte, virtual_address, input ready);
  modport sink (input valid, mode, load_address, load_byte, virtual_address, output ready);
endinterface

interface tlptw_rsp_if;
  import tlptw_pkg::*;
  logic             valid;
  logic             ready;
  logic             outer_valid;
  logic             inner_valid;
  logic [AddrW-1:0] physical_address;
  logic [WordW-1:0] data_word;
  logic             range_error;

  modport source (output valid, outer_valid, inner_valid, physical_address, data_word,
                  range_error, input ready);
  modport sink (input valid, outer_valid, inner_valid, physical_address, data_word,
                range_error, output ready);
endinterface

interface tlptw_cfg_if;
  import tlptw_pkg::*;
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] page_table_base;

  modport source (output valid, page_table_base, input ready);
  modport sink (input valid, page_table_base, output ready);
endinterface

[design/tlptw_ram.sv]
// One byte-wide bank of physical memory: one write port, one registered read port.
module tlptw_ram
  import tlptw_pkg::*;
(
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [RowW-1:0] wr_row_i,
  input  logic [7:0]      wr_data_i,
  input  logic            rd_en_i,
  input  logic [RowW-1:0] rd_row_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem [BankDepth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/two_level_page_table_walk.sv]
// Two-level page table walk over a 4096-byte physical memory.
//
// Channels: req_i carries load and translate beats, rsp_o carries one result beat per
// translate, cfg_i writes the outer table base (always ready; write only while idle).
// A load beat writes one byte; it gives no result.
// A translate beat walks outer entry, inner entry and data word, one word read per
// cycle from four byte banks, so a word at any byte alignment is read in one access.
// On a full walk the idle step reads the outer entry, the outer step the inner entry,
// the inner step the data word, and the data step writes the output register; the
// walk is paced by the chain of three dependent reads through the single read port
// of each bank. A miss or a range error ends the walk early through the emit step.
// A new beat is taken once the microprogram is back at its idle step, while the
// previous result may still wait in the output register.
// If the receiver stalls with a result pending, the walk holds at its final step.
// Reset clears the sequencer, the output valid and the base register; memory contents
// are undefined until loaded.
module two_level_page_table_walk
  import tlptw_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  tlptw_cfg_if.sink   cfg_i,
  tlptw_req_if.sink   req_i,
  tlptw_rsp_if.source rsp_o
);

  logic [StepW-1:0] pc_q, pc_d;
  ctrl_t            cw;

  logic [AddrW-1:0] base_q;
  logic [VaW-1:0]   va_q, va_d;
  logic             outer_q, outer_d, inner_q, inner_d, rerr_q, rerr_d;
  logic [AddrW-1:0] pa_q, pa_d;

  logic             out_valid_q, out_valid_d;
  logic             out_outer_q, out_inner_q, out_rerr_q;
  logic [AddrW-1:0] out_pa_q;
  logic [WordW-1:0] out_word_q;
  logic             out_load;

  logic             req_fire, wr_en, rd_en;
  logic [AddrW:0]   rd_addr;
  logic [WordW-1:0] rdata;
  logic             test_fail, range_fail;

  logic [7:0]          bank_rd   [Banks];
  logic [RowW-1:0]     bank_row  [Banks];
  logic [Banks-1:0]    bank_oob, oob_q;
  logic [BankSelW-1:0] off_q;

  assign cw = ucode(pc_q);

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = cw.wait_in;
  assign req_fire    = req_i.valid && req_i.ready;
  assign wr_en       = req_fire && (req_i.mode == MODE_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      base_q <= cfg_i.page_table_base;
    end
  end

  // read address for the step; bit 12 flags a table address past the end
  always_comb begin
    case (cw.sel)
      AS_OUTER: rd_addr = {1'b0, base_q} + {7'b0, req_i.virtual_address[13:10], 2'b00};
      AS_INNER: rd_addr = {1'b0, rdata[31:20]} + {7'b0, va_q[9:6], 2'b00};
      AS_PA:    rd_addr = {1'b0, rdata[31:26], va_q[OffW-1:0]};
      default:  rd_addr = '0;
    endcase
  end

  assign test_fail  = cw.test_ok && !rdata[0];
  assign range_fail = cw.chk_range && rd_addr[AddrW] && !test_fail;

  always_comb begin
    pc_d     = pc_q;
    va_d     = va_q;
    outer_d  = outer_q;
    inner_d  = inner_q;
    rerr_d   = rerr_q;
    pa_d     = pa_q;
    rd_en    = 1'b0;
    out_load = 1'b0;
    if (cw.emit) begin
      if (!out_valid_q || rsp_o.ready) begin
        out_load = 1'b1;
        pc_d     = cw.next;
      end
    end else if (!cw.wait_in || (req_fire && req_i.mode == MODE_XLATE)) begin
      if (cw.wait_in) begin
        va_d    = req_i.virtual_address;
        outer_d = 1'b0;
        inner_d = 1'b0;
        rerr_d  = 1'b0;
        pa_d    = '0;
      end
      if (test_fail || range_fail) begin
        rerr_d = range_fail;
        pc_d   = S_EMIT;
      end else begin
        rd_en = (cw.sel != AS_NONE);
        if (cw.set_outer) outer_d = 1'b1;
        if (cw.set_inner) begin
          inner_d = 1'b1;
          pa_d    = rd_addr[AddrW-1:0];
        end
        pc_d = cw.next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q    <= va_d;
    outer_q <= outer_d;
    inner_q <= inner_d;
    rerr_q  <= rerr_d;
    pa_q    <= pa_d;
  end

  // four byte banks; bank b holds bytes whose address has low bits b
  for (genvar b = 0; b < Banks; b++) begin : g_bank
    logic [RowW:0] row;
    always_comb begin
      row = {1'b0, rd_addr[AddrW-1:BankSelW]}
          + {{RowW{1'b0}}, (BankSelW'(b) < rd_addr[BankSelW-1:0])};
    end
    assign bank_row[b] = row[RowW-1:0];
    assign bank_oob[b] = row[RowW];

    tlptw_ram u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en && (req_i.load_address[BankSelW-1:0] == BankSelW'(b))),
      .wr_row_i  (req_i.load_address[AddrW-1:BankSelW]),
      .wr_data_i (req_i.load_byte),
      .rd_en_i   (rd_en),
      .rd_row_i  (bank_row[b]),
      .rd_data_o (bank_rd[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      oob_q <= bank_oob;
      off_q <= rd_addr[BankSelW-1:0];
    end
  end

  // big-endian assembly; bytes past the end read as zero
  always_comb begin
    logic [BankSelW-1:0] idx;
    rdata = '0;
    for (int k = 0; k < Banks; k++) begin
      idx = off_q + BankSelW'(k);
      rdata[WordW-1-8*k -: 8] = bank_rd[idx] & {8{!oob_q[idx]}};
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_outer_q <= outer_q;
      out_inner_q <= inner_q;
      out_rerr_q  <= rerr_q;
      out_pa_q    <= pa_q;
      out_word_q  <= cw.emit_word ? rdata : '0;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.outer_valid      = out_outer_q;
  assign rsp_o.inner_valid      = out_inner_q;
  assign rsp_o.physical_address = out_pa_q;
  assign rsp_o.data_word        = out_word_q;
  assign rsp_o.range_error      = out_rerr_q;

endmodule

[tb/two_level_page_table_walk_tb.sv]
// Self-checking testbench for the two-level page table walk: builds tables by loads, checks walks.
module two_level_page_table_walk_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlptw_pkg::*;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] load_address;
    logic [7:0]       load_byte;
    logic [VaW-1:0]   virtual_address;
  } walk_req_t;

  typedef struct packed {
    logic             outer_valid;
    logic             inner_valid;
    logic [AddrW-1:0] physical_address;
    logic [WordW-1:0] data_word;
    logic             range_error;
  } walk_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlptw_cfg_if cfg ();
  tlptw_req_if req ();
  tlptw_rsp_if rsp ();

  two_level_page_table_walk dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the block: memory image, which bytes were loaded, table base
  logic [7:0]       mem_img [MemBytes];
  bit               loaded [MemBytes];
  logic [AddrW-1:0] table_base;
  bit               read_hole;

  walk_req_t   req_pend_q[$];
  walk_rsp_t   walk_exp_q[$];
  int unsigned items_queued;
  int unsigned items_taken;
  int unsigned xlates_taken;
  int unsigned rsps_seen;
  int unsigned errors;

  int unsigned req_gap, req_calm, rsp_stall, rsp_calm;
  walk_req_t   next_beat;
  walk_rsp_t   want;

  function automatic int unsigned pick_idle(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(16, 48);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [7:0] peek_byte(input int unsigned a);
    if (a >= MemBytes) return 8'h00;
    if (!loaded[a]) read_hole = 1'b1;
    return mem_img[a];
  endfunction

  function automatic logic [WordW-1:0] peek_word(input int unsigned a);
    return {peek_byte(a), peek_byte(a + 1), peek_byte(a + 2), peek_byte(a + 3)};
  endfunction

  function automatic bit word_loaded(input int unsigned a);
    bit ok;
    ok = 1'b1;
    for (int k = 0; k < 4; k++)
      if (a + k < MemBytes && !loaded[a + k]) ok = 1'b0;
    return ok;
  endfunction

  // outer entry -> inner entry -> data word; any miss or range error zeroes the rest
  function automatic walk_rsp_t walk_tables(input logic [VaW-1:0] va);
    walk_rsp_t        r;
    int unsigned      oaddr, iaddr;
    logic [WordW-1:0] oent, ient;
    r = '0;
    oaddr = table_base + 4 * va[VaW-1:VaW-4];
    if (oaddr >= MemBytes) begin
      r.range_error = 1'b1;
      return r;
    end
    oent = peek_word(oaddr);
    if (!oent[0]) return r;
    iaddr = oent[31:20] + 4 * va[9:6];
    if (iaddr >= MemBytes) begin
      r.range_error = 1'b1;
      return r;
    end
    r.outer_valid = 1'b1;
    ient = peek_word(iaddr);
    if (!ient[0]) return r;
    r.inner_valid      = 1'b1;
    r.physical_address = {ient[31:26], va[OffW-1:0]};
    r.data_word        = peek_word(r.physical_address);
    return r;
  endfunction

  task automatic queue_load(input int unsigned a, input logic [7:0] b);
    walk_req_t it;
    it.mode            = MODE_LOAD;
    it.load_address    = a[AddrW-1:0];
    it.load_byte       = b;
    it.virtual_address = VaW'($urandom);
    req_pend_q.push_back(it);
    items_queued++;
    mem_img[a] = b;
    loaded[a]  = 1'b1;
  endtask

  task automatic queue_word(input int unsigned a, input logic [WordW-1:0] w);
    for (int k = 0; k < 4; k++)
      if (a + k < MemBytes) queue_load(a + k, w[31 - 8 * k -: 8]);
  endtask

  // only issued when the walk touches no byte that was never loaded
  task automatic try_translate(input logic [VaW-1:0] va, output bit ok);
    walk_req_t it;
    walk_rsp_t r;
    read_hole = 1'b0;
    r  = walk_tables(va);
    ok = !read_hole;
    if (ok) begin
      it.mode            = MODE_XLATE;
      it.load_address    = AddrW'($urandom);
      it.load_byte       = 8'($urandom);
      it.virtual_address = va;
      req_pend_q.push_back(it);
      items_queued++;
      walk_exp_q.push_back(r);
    end
  endtask

  // load whatever entries and data the walk needs, sometimes overwriting, then translate
  task automatic build_walk(input logic [3:0] o, input logic [3:0] i, input logic [5:0] off);
    int unsigned      oaddr, iaddr;
    logic [WordW-1:0] ent;
    logic [AddrW-1:0] itab, pa;
    logic [5:0]       frame;
    bit               vbit, ok;
    oaddr = table_base + 4 * o;
    if (oaddr < MemBytes) begin
      if (!word_loaded(oaddr) || $urandom_range(0, 7) == 0) begin
        itab = ($urandom_range(0, 7) == 0) ? AddrW'($urandom_range(4036, 4095))
                                           : AddrW'($urandom);
        vbit = ($urandom_range(0, 7) != 0);
        queue_word(oaddr, {itab, 19'($urandom), vbit});
      end
      ent = peek_word(oaddr);
      iaddr = ent[31:20] + 4 * i;
      if (ent[0] && iaddr < MemBytes) begin
        if (!word_loaded(iaddr) || $urandom_range(0, 7) == 0) begin
          frame = ($urandom_range(0, 7) == 0) ? 6'h3f : 6'($urandom);
          vbit  = ($urandom_range(0, 7) != 0);
          queue_word(iaddr, {frame, 25'($urandom), vbit});
        end
        ent = peek_word(iaddr);
        if (ent[0]) begin
          pa = {ent[31:26], off};
          if (!word_loaded(pa) || $urandom_range(0, 3) == 0) queue_word(pa, $urandom);
        end
      end
    end
    try_translate({o, i, off}, ok);
  endtask

  task automatic write_base(input logic [AddrW-1:0] b);
    @(posedge clk_i);
    cfg.valid           <= 1'b1;
    cfg.page_table_base <= b;
    do @(posedge clk_i); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
    table_base = b;
  endtask

  // loads give no result, so allow the walk latency after the last beat
  task automatic wait_idle();
    while (items_taken != items_queued || walk_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (errors < 40)
      $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, exp_val);
    errors++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        items_taken <= items_taken + 1;
        if (req.mode == MODE_XLATE) xlates_taken <= xlates_taken + 1;
      end
      if (!req.valid || req.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req.valid <= 1'b0;
        end else if (req_pend_q.size() != 0) begin
          next_beat = req_pend_q.pop_front();
          req.valid           <= 1'b1;
          req.mode            <= next_beat.mode;
          req.load_address    <= next_beat.load_address;
          req.load_byte       <= next_beat.load_byte;
          req.virtual_address <= next_beat.virtual_address;
          req_gap = pick_idle(req_calm);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (walk_exp_q.size() == 0 || xlates_taken <= rsps_seen) begin
          report_mismatch("unexpected result beat", 0, 0);
        end else begin
          want = walk_exp_q.pop_front();
          rsps_seen++;
          if (rsp.outer_valid !== want.outer_valid)
            report_mismatch("outer_valid", rsp.outer_valid, want.outer_valid);
          if (rsp.inner_valid !== want.inner_valid)
            report_mismatch("inner_valid", rsp.inner_valid, want.inner_valid);
          if (rsp.physical_address !== want.physical_address)
            report_mismatch("physical_address", rsp.physical_address, want.physical_address);
          if (rsp.data_word !== want.data_word)
            report_mismatch("data_word", rsp.data_word, want.data_word);
          if (rsp.range_error !== want.range_error)
            report_mismatch("range_error", rsp.range_error, want.range_error);
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        rsp_stall = pick_idle(rsp_calm);
      end
    end
  end

  initial begin
    int unsigned      p, r, phase_end;
    int unsigned      phase_len [6];
    logic [AddrW-1:0] base;
    bit               ok;

    rst_ni              = 1'b0;
    req.valid           = 1'b0;
    req.mode            = MODE_LOAD;
    req.load_address    = '0;
    req.load_byte       = '0;
    req.virtual_address = '0;
    rsp.ready           = 1'b0;
    cfg.valid           = 1'b0;
    cfg.page_table_base = '0;
    table_base          = '0;
    phase_len = '{90, 45, 125, 115, 125, 125};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (p = 0; p < 6; p++) begin
      case (p)
        0:       base = 12'd0;
        1:       base = 12'd4095;  // outer 0 straddles the end, the rest out of range
        3:       base = 12'd4068;
        5:       base = 12'd4092;
        default: base = AddrW'($urandom_range(0, 4031));
      endcase
      write_base(base);

      if (p == 0) begin
        // outer miss
        queue_word(4, 32'hffff_fffe);
        try_translate({4'd1, 4'd0, 6'd0}, ok);
        // full hit, all-ones address, data word at the last byte
        queue_word(60, 32'h8000_0001);
        queue_word(12'h83c, 32'hfc00_0001);
        queue_word(12'hfff, 32'ha500_0000);
        try_translate(14'h3fff, ok);
        // inner miss
        queue_word(12'h800, 32'h0000_0000);
        try_translate({4'd15, 4'd0, 6'd0}, ok);
        // inner table address runs past the end
        queue_word(8, 32'hfff0_0001);
        try_translate({4'd2, 4'd1, 6'd5}, ok);
      end

      phase_end = items_queued + phase_len[p];
      while (items_queued < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          build_walk(4'($urandom), 4'($urandom), 6'($urandom));
        end else begin
          ok = 1'b0;
          if (r < 80) try_translate(VaW'($urandom), ok);
          if (!ok) queue_load($urandom_range(0, MemBytes - 1), 8'($urandom));
        end
      end
      wait_idle();
    end

    if (errors == 0)
      $display("two_level_page_table_walk_tb passed");
    else
      $display("two_level_page_table_walk_tb failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("two_level_page_table_walk_tb failed");
    $finish;
  end

endmodule

[sim.f]
design/tlptw_pkg.sv
design/tlptw_if.sv
design/tlptw_ram.sv
design/two_level_page_table_walk.sv
tb/two_level_page_table_walk_tb.sv
